@@ src/nmea_rmc_parser_assert.svh @@
// assertion macros for the rmc sentence parser
// no dependencies; included by the rtl files that carry assertions
`ifndef NMEA_RMC_PARSER_ASSERT_SVH
`define NMEA_RMC_PARSER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define NRMC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NRMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/nrmc_pkg.sv @@
// shared types and constants for the rmc sentence parser
// no dependencies
`default_nettype none

package nrmc_pkg;

	// character codes
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_S     = 8'h53;
	localparam logic [7:0] CHAR_W     = 8'h57;

	// sentence identifier "$GPRMC"
	localparam int ID_LEN = 6;
	localparam int ID_IDX_W = $clog2(ID_LEN);
	localparam logic [7:0] RMC_ID [ID_LEN] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

	// field numbers
	localparam int FN_W = 4;
	localparam logic [FN_W-1:0] FIELD_ID       = 4'd0;
	localparam logic [FN_W-1:0] FIELD_TIME     = 4'd1;
	localparam logic [FN_W-1:0] FIELD_LAT      = 4'd3;
	localparam logic [FN_W-1:0] FIELD_LAT_HEMI = 4'd4;
	localparam logic [FN_W-1:0] FIELD_LON      = 4'd5;
	localparam logic [FN_W-1:0] FIELD_LON_HEMI = 4'd6;
	localparam logic [FN_W-1:0] FIELD_DATE     = 4'd9;
	localparam logic [FN_W-1:0] FIELD_LAST     = 4'd15;

	// number formats, all digit stores are bcd
	localparam int INT_DIGITS  = 6;
	localparam int COORD_DIGITS = 5;
	localparam int FRAC_KEPT   = 5;
	localparam int BIN_W       = 17;
	localparam int MAG_W       = 34;
	localparam int COORD_W     = 35;
	localparam int FIELD7_W    = 7;
	localparam int COORD_SCALE = 100000;

	typedef struct packed {
		logic [4*INT_DIGITS-1:0]   time_bcd;
		logic [4*COORD_DIGITS-1:0] lat_int;
		logic [4*FRAC_KEPT-1:0]    lat_frac;
		logic                      south;
		logic [4*COORD_DIGITS-1:0] lon_int;
		logic [4*FRAC_KEPT-1:0]    lon_frac;
		logic                      west;
		logic [4*INT_DIGITS-1:0]   date_bcd;
	} rec_t;

	typedef struct packed {
		logic [FIELD7_W-1:0] hour;
		logic [FIELD7_W-1:0] minute;
		logic [FIELD7_W-1:0] second;
		logic [BIN_W-1:0]    lat_int;
		logic [BIN_W-1:0]    lat_frac;
		logic                south;
		logic [BIN_W-1:0]    lon_int;
		logic [BIN_W-1:0]    lon_frac;
		logic                west;
		logic [FIELD7_W-1:0] day;
		logic [FIELD7_W-1:0] month;
		logic [FIELD7_W-1:0] year;
	} cv_t;

endpackage

`default_nettype wire

@@ src/nrmc_parser.sv @@
// input register and per-character line parser; emits a bcd record per rmc line
// depends on nrmc_pkg and nmea_rmc_parser_assert.svh
`default_nettype none
`include "nmea_rmc_parser_assert.svh"

module nrmc_parser #(
	parameter int LINE_MAX = 79,
	parameter int FIELD_MAX = 19,
	parameter int FRACTION_DIGITS = 5
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         rx_valid,
	output logic              rx_ready,
	input  wire logic [7:0]   rx_byte,
	output logic              rec_valid,
	input  wire logic         rec_ready,
	output nrmc_pkg::rec_t    rec
);
	import nrmc_pkg::*;

	localparam int LP_W = $clog2(LINE_MAX + 1);
	localparam int FP_W = $clog2(FIELD_MAX + 1);
	localparam int FC_W = $clog2(FRACTION_DIGITS + 1);

	logic [7:0] byte_s1;
	logic       valid_s1;

	logic [LP_W-1:0]           line_pos_q, line_pos_nxt;
	logic [FN_W-1:0]           field_num_q, field_num_nxt;
	logic [FP_W-1:0]           field_pos_q, field_pos_nxt;
	logic                      id_q, id_nxt;
	logic [4*INT_DIGITS-1:0]   int_q, int_nxt;
	logic [4*FRAC_KEPT-1:0]    frac_q, frac_nxt;
	logic [FC_W-1:0]           frac_cnt_q, frac_cnt_nxt;
	logic                      point_q, point_nxt;
	logic [4*INT_DIGITS-1:0]   time_q, time_nxt;
	logic [4*COORD_DIGITS-1:0] lat_int_q, lat_int_nxt, lon_int_q, lon_int_nxt;
	logic [4*FRAC_KEPT-1:0]    lat_frac_q, lat_frac_nxt, lon_frac_q, lon_frac_nxt;
	logic                      south_q, south_nxt, west_q, west_nxt;
	logic [4*INT_DIGITS-1:0]   date_q, date_nxt;

	logic                      rec_valid_q;
	rec_t                      rec_q;

	// values after closing the current field
	logic [4*COORD_DIGITS-1:0] coord_int_cl;
	logic [4*INT_DIGITS-1:0]   time_cl, date_cl;
	logic [4*COORD_DIGITS-1:0] lat_int_cl, lon_int_cl;
	logic [4*FRAC_KEPT-1:0]    lat_frac_cl, lon_frac_cl;
	logic                      id_cl;
	rec_t                      rec_cl;

	logic       is_digit;
	logic [3:0] digit;
	logic       want_rec, rec_free, s1_fire;

	always_comb begin
		// integer part of a coordinate saturates at 99999
		if (int_q[4*INT_DIGITS-1 -: 4] != 4'd0) begin
			coord_int_cl = {COORD_DIGITS{4'd9}};
		end else begin
			coord_int_cl = int_q[4*COORD_DIGITS-1:0];
		end
		time_cl     = (field_num_q == FIELD_TIME) ? int_q : time_q;
		date_cl     = (field_num_q == FIELD_DATE) ? int_q : date_q;
		lat_int_cl  = (field_num_q == FIELD_LAT) ? coord_int_cl : lat_int_q;
		lat_frac_cl = (field_num_q == FIELD_LAT) ? frac_q : lat_frac_q;
		lon_int_cl  = (field_num_q == FIELD_LON) ? coord_int_cl : lon_int_q;
		lon_frac_cl = (field_num_q == FIELD_LON) ? frac_q : lon_frac_q;
		id_cl = id_q && !(field_num_q == FIELD_ID && field_pos_q != FP_W'(ID_LEN));

		rec_cl.time_bcd = time_cl;
		rec_cl.lat_int  = lat_int_cl;
		rec_cl.lat_frac = lat_frac_cl;
		rec_cl.south    = south_q;
		rec_cl.lon_int  = lon_int_cl;
		rec_cl.lon_frac = lon_frac_cl;
		rec_cl.west     = west_q;
		rec_cl.date_bcd = date_cl;
	end

	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign digit    = byte_s1[3:0];

	// only a newline that closes an rmc line needs room downstream
	assign want_rec  = valid_s1 && (byte_s1 == CHAR_LF) && id_cl;
	assign rec_free  = !rec_valid_q || rec_ready;
	assign s1_fire   = valid_s1 && (!want_rec || rec_free);
	assign rx_ready  = !valid_s1 || s1_fire;

	always_comb begin
		line_pos_nxt  = line_pos_q;
		field_num_nxt = field_num_q;
		field_pos_nxt = field_pos_q;
		id_nxt        = id_q;
		int_nxt       = int_q;
		frac_nxt      = frac_q;
		frac_cnt_nxt  = frac_cnt_q;
		point_nxt     = point_q;
		time_nxt      = time_q;
		lat_int_nxt   = lat_int_q;
		lat_frac_nxt  = lat_frac_q;
		lon_int_nxt   = lon_int_q;
		lon_frac_nxt  = lon_frac_q;
		south_nxt     = south_q;
		west_nxt      = west_q;
		date_nxt      = date_q;

		if (s1_fire && byte_s1 != CHAR_CR) begin
			if (byte_s1 == CHAR_LF) begin
				// end of line: everything back to the reset values
				line_pos_nxt  = '0;
				field_num_nxt = '0;
				field_pos_nxt = '0;
				id_nxt        = 1'b1;
				int_nxt       = '0;
				frac_nxt      = '0;
				frac_cnt_nxt  = '0;
				point_nxt     = 1'b0;
				time_nxt      = '0;
				lat_int_nxt   = '0;
				lat_frac_nxt  = '0;
				lon_int_nxt   = '0;
				lon_frac_nxt  = '0;
				south_nxt     = 1'b0;
				west_nxt      = 1'b0;
				date_nxt      = '0;
			end else if (line_pos_q < LP_W'(LINE_MAX)) begin
				line_pos_nxt = line_pos_q + 1'b1;
				if (byte_s1 == CHAR_COMMA) begin
					id_nxt        = id_cl;
					time_nxt      = time_cl;
					date_nxt      = date_cl;
					lat_int_nxt   = lat_int_cl;
					lat_frac_nxt  = lat_frac_cl;
					lon_int_nxt   = lon_int_cl;
					lon_frac_nxt  = lon_frac_cl;
					field_pos_nxt = '0;
					int_nxt       = '0;
					frac_nxt      = '0;
					frac_cnt_nxt  = '0;
					point_nxt     = 1'b0;
					if (field_num_q != FIELD_LAST) begin
						field_num_nxt = field_num_q + 1'b1;
					end
				end else if (field_pos_q < FP_W'(FIELD_MAX)) begin
					if (field_num_q == FIELD_ID) begin
						if (field_pos_q >= FP_W'(ID_LEN)) begin
							id_nxt = 1'b0;
						end else if (byte_s1 != RMC_ID[field_pos_q[ID_IDX_W-1:0]]) begin
							id_nxt = 1'b0;
						end
					end
					if (field_pos_q == '0) begin
						if (field_num_q == FIELD_LAT_HEMI) begin
							south_nxt = (byte_s1 == CHAR_S);
						end
						if (field_num_q == FIELD_LON_HEMI) begin
							west_nxt = (byte_s1 == CHAR_W);
						end
					end
					if (is_digit) begin
						if (!point_q) begin
							// dropping the top bcd digit is the modulo one million
							int_nxt = {int_q[4*(INT_DIGITS-1)-1:0], digit};
						end else if (frac_cnt_q < FC_W'(FRACTION_DIGITS)) begin
							// digits past the fifth never reach the result; past FRACTION_DIGITS they are not counted either
							for (int i = 0; i < FRAC_KEPT; i++) begin
								if (int'(frac_cnt_q) == i) begin
									frac_nxt[(FRAC_KEPT-1-i)*4 +: 4] = digit;
								end
							end
							frac_cnt_nxt = frac_cnt_q + 1'b1;
						end
					end else if (byte_s1 == CHAR_POINT) begin
						point_nxt = 1'b1;
					end
					field_pos_nxt = field_pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rec_valid_q <= 1'b0;
			line_pos_q  <= '0;
			field_num_q <= '0;
			field_pos_q <= '0;
			id_q        <= 1'b1;
			int_q       <= '0;
			frac_q      <= '0;
			frac_cnt_q  <= '0;
			point_q     <= 1'b0;
			time_q      <= '0;
			lat_int_q   <= '0;
			lat_frac_q  <= '0;
			lon_int_q   <= '0;
			lon_frac_q  <= '0;
			south_q     <= 1'b0;
			west_q      <= 1'b0;
			date_q      <= '0;
		end else begin
			if (rx_ready) begin
				valid_s1 <= rx_valid;
			end
			if (rec_free) begin
				rec_valid_q <= s1_fire && want_rec;
			end
			line_pos_q  <= line_pos_nxt;
			field_num_q <= field_num_nxt;
			field_pos_q <= field_pos_nxt;
			id_q        <= id_nxt;
			int_q       <= int_nxt;
			frac_q      <= frac_nxt;
			frac_cnt_q  <= frac_cnt_nxt;
			point_q     <= point_nxt;
			time_q      <= time_nxt;
			lat_int_q   <= lat_int_nxt;
			lat_frac_q  <= lat_frac_nxt;
			lon_int_q   <= lon_int_nxt;
			lon_frac_q  <= lon_frac_nxt;
			south_q     <= south_nxt;
			west_q      <= west_nxt;
			date_q      <= date_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
		if (s1_fire && want_rec) begin
			rec_q <= rec_cl;
		end
	end

	assign rec_valid = rec_valid_q;
	assign rec       = rec_q;

	`NRMC_ASSERT_NEXT(a_newline_clears, clk, arst_n,
		s1_fire && byte_s1 == CHAR_LF,
		line_pos_q == '0 && field_num_q == '0 && field_pos_q == '0 && id_q,
		"line state not cleared after newline")
	`NRMC_ASSERT_SAME(a_pos_bounds, clk, arst_n, 1'b1,
		line_pos_q <= LP_W'(LINE_MAX) && field_pos_q <= FP_W'(FIELD_MAX),
		"line or field position past its limit")
	`NRMC_ASSERT_NEXT(a_rec_holds, clk, arst_n, rec_valid_q && !rec_ready,
		rec_valid_q && $stable(rec_q), "waiting record lost or changed")

endmodule

`default_nettype wire

@@ src/nrmc_conv.sv @@
// bcd to binary conversion stage for one parsed record
// depends on nrmc_pkg
`default_nettype none

module nrmc_conv (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            rec_valid,
	output logic                 rec_ready,
	input  wire nrmc_pkg::rec_t  rec,
	output logic                 cv_valid,
	input  wire logic            cv_ready,
	output nrmc_pkg::cv_t        cv
);
	import nrmc_pkg::*;

	localparam logic [BIN_W-1:0] POW10 [COORD_DIGITS] = '{17'd1, 17'd10, 17'd100, 17'd1000,
		17'd10000};

	function automatic logic [FIELD7_W-1:0] bcd2_bin(input logic [7:0] b);
		return FIELD7_W'({3'b000, b[7:4]} * 7'd10) + FIELD7_W'(b[3:0]);
	endfunction

	function automatic logic [BIN_W-1:0] bcd5_bin(input logic [4*COORD_DIGITS-1:0] b);
		logic [BIN_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < COORD_DIGITS; i++) begin
			acc = acc + BIN_W'(b[i*4 +: 4]) * POW10[i];
		end
		return acc;
	endfunction

	logic cv_valid_s3;
	cv_t  cv_s3, cv_nxt;

	assign rec_ready = !cv_valid_s3 || cv_ready;

	always_comb begin
		cv_nxt.hour     = bcd2_bin(rec.time_bcd[23:16]);
		cv_nxt.minute   = bcd2_bin(rec.time_bcd[15:8]);
		cv_nxt.second   = bcd2_bin(rec.time_bcd[7:0]);
		cv_nxt.lat_int  = bcd5_bin(rec.lat_int);
		cv_nxt.lat_frac = bcd5_bin(rec.lat_frac);
		cv_nxt.south    = rec.south;
		cv_nxt.lon_int  = bcd5_bin(rec.lon_int);
		cv_nxt.lon_frac = bcd5_bin(rec.lon_frac);
		cv_nxt.west     = rec.west;
		cv_nxt.day      = bcd2_bin(rec.date_bcd[23:16]);
		cv_nxt.month    = bcd2_bin(rec.date_bcd[15:8]);
		cv_nxt.year     = bcd2_bin(rec.date_bcd[7:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_valid_s3 <= 1'b0;
		end else if (rec_ready) begin
			cv_valid_s3 <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_ready && rec_valid) begin
			cv_s3 <= cv_nxt;
		end
	end

	assign cv_valid = cv_valid_s3;
	assign cv       = cv_s3;

endmodule

`default_nettype wire

@@ src/nrmc_out.sv @@
// coordinate scaling, hemisphere sign and output register
// depends on nrmc_pkg
`default_nettype none

module nrmc_out (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cv_valid,
	output logic                                cv_ready,
	input  wire nrmc_pkg::cv_t                  cv,
	output logic                                fix_valid,
	input  wire logic                           fix_stall,
	output logic [nrmc_pkg::FIELD7_W-1:0]       hour,
	output logic [nrmc_pkg::FIELD7_W-1:0]       minute,
	output logic [nrmc_pkg::FIELD7_W-1:0]       second,
	output logic signed [nrmc_pkg::COORD_W-1:0] latitude,
	output logic signed [nrmc_pkg::COORD_W-1:0] longitude,
	output logic [nrmc_pkg::FIELD7_W-1:0]       day,
	output logic [nrmc_pkg::FIELD7_W-1:0]       month,
	output logic [nrmc_pkg::FIELD7_W-1:0]       year
);
	import nrmc_pkg::*;

	logic               fix_valid_q;
	logic [MAG_W-1:0]   lat_mag, lon_mag;
	logic [COORD_W-1:0] lat_nxt, lon_nxt;

	// whole part in units of 1e-5 plus the five kept fraction digits
	assign lat_mag = MAG_W'(cv.lat_int) * MAG_W'(COORD_SCALE) + MAG_W'(cv.lat_frac);
	assign lon_mag = MAG_W'(cv.lon_int) * MAG_W'(COORD_SCALE) + MAG_W'(cv.lon_frac);
	assign lat_nxt = cv.south ? (COORD_W'(0) - {1'b0, lat_mag}) : {1'b0, lat_mag};
	assign lon_nxt = cv.west ? (COORD_W'(0) - {1'b0, lon_mag}) : {1'b0, lon_mag};

	assign cv_ready = !fix_valid_q || !fix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_valid_q <= 1'b0;
		end else if (cv_ready) begin
			fix_valid_q <= cv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cv_ready && cv_valid) begin
			hour      <= cv.hour;
			minute    <= cv.minute;
			second    <= cv.second;
			latitude  <= $signed(lat_nxt);
			longitude <= $signed(lon_nxt);
			day       <= cv.day;
			month     <= cv.month;
			year      <= cv.year;
		end
	end

	assign fix_valid = fix_valid_q;

endmodule

`default_nettype wire

@@ src/nmea_rmc_parser.sv @@
// after its newline is taken, a fix is registered in turn in the record, conversion and output registers
// throughput: one character per cycle; a waiting fix does not block further characters
// until the next complete rmc line finds the record stage full as well
// reset: asynchronous, clears all handshake and line state; no clearing pass is needed
// top level of the rmc sentence parser; depends on nrmc_pkg, nrmc_parser, nrmc_conv, nrmc_out
`default_nettype none

module nmea_rmc_parser #(
	parameter int LINE_MAX = 79,
	parameter int FIELD_MAX = 19,
	parameter int FRACTION_DIGITS = 5
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           rx_valid,
	output logic                                rx_stall,
	input  wire logic [7:0]                     rx_byte,
	output logic                                fix_valid,
	input  wire logic                           fix_stall,
	output logic [nrmc_pkg::FIELD7_W-1:0]       hour,
	output logic [nrmc_pkg::FIELD7_W-1:0]       minute,
	output logic [nrmc_pkg::FIELD7_W-1:0]       second,
	output logic signed [nrmc_pkg::COORD_W-1:0] latitude,
	output logic signed [nrmc_pkg::COORD_W-1:0] longitude,
	output logic [nrmc_pkg::FIELD7_W-1:0]       day,
	output logic [nrmc_pkg::FIELD7_W-1:0]       month,
	output logic [nrmc_pkg::FIELD7_W-1:0]       year
);
	import nrmc_pkg::*;

	logic rx_ready;
	logic rec_valid, rec_ready;
	rec_t rec;
	logic cv_valid, cv_ready;
	cv_t  cv;

	assign rx_stall = !rx_ready;

	nrmc_parser #(
		.LINE_MAX(LINE_MAX),
		.FIELD_MAX(FIELD_MAX),
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.rec_valid(rec_valid),
		.rec_ready(rec_ready),
		.rec(rec)
	);

	nrmc_conv u_conv (
		.clk(clk),
		.arst_n(arst_n),
		.rec_valid(rec_valid),
		.rec_ready(rec_ready),
		.rec(rec),
		.cv_valid(cv_valid),
		.cv_ready(cv_ready),
		.cv(cv)
	);

	nrmc_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.cv_valid(cv_valid),
		.cv_ready(cv_ready),
		.cv(cv),
		.fix_valid(fix_valid),
		.fix_stall(fix_stall),
		.hour(hour),
		.minute(minute),
		.second(second),
		.latitude(latitude),
		.longitude(longitude),
		.day(day),
		.month(month),
		.year(year)
	);

endmodule

`default_nettype wire
